// ===== hw/rtl/imts_pkg.sv =====
// Shared types and constants for the I2C master transaction sequencer.
package imts_pkg;

    localparam int unsigned BUFFER_DEPTH_DEFAULT = 8;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_WRITE = 3'd1,
        OP_READ  = 3'd2,
        OP_EVENT = 3'd3,
        OP_POP   = 3'd4
    } t_op;

    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_REP_START   = 8'h10;
    localparam logic [7:0] ST_W_ADR_ACK   = 8'h18;
    localparam logic [7:0] ST_W_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_R_ADR_ACK   = 8'h40;
    localparam logic [7:0] ST_R_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_R_DATA_NACK = 8'h58;

    localparam logic [7:0] EMPTY_BYTE = 8'h88;

    typedef struct packed {
        logic write;
        logic enable;
        logic int_enable;
        logic clear_flag;
        logic start;
        logic stop;
        logic ack;
    } t_ctl;

endpackage

// ===== hw/rtl/i2c_master_transaction_sequencer_unit.sv =====
// Top level of the I2C master transaction sequencer: command decode and bus event handling.
//
// Each input item is a command: load a transmit byte, start a write, start a read,
// report a bus status event, or pop a received byte. Each item produces exactly one
// result item carrying the control word for the bus engine, an optional transmit
// byte, the busy and has-data flags and the popped byte.
// Both channels use valid and stall; an item moves when valid is high and stall low.
// An accepted item is held in an input register, decoded combinationally and written to
// the result register together with the state update. One item is taken every cycle
// while the receiver does not stall; the transmit and receive stores are small RAMs
// whose registered read port is aligned with the result register.
// When the receiver stalls, the result holds and the input register keeps its item;
// the input stall rises only once both registers are full.
// Reset clears the counters, the busy flag and both valid flags. Store contents are
// not cleared; the user must see that an entry is only read after it has been written.
module i2c_master_transaction_sequencer_unit #(
    parameter int unsigned BUFFER_DEPTH = imts_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_operation,
    input  logic [2:0] i_tx_index,
    input  logic [7:0] i_byte_value,
    input  logic [6:0] i_slave_address,
    input  logic [3:0] i_byte_count,
    input  logic [7:0] i_status_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_ctl_write,
    output logic       o_ctl_enable,
    output logic       o_ctl_int_enable,
    output logic       o_ctl_clear_flag,
    output logic       o_ctl_start,
    output logic       o_ctl_stop,
    output logic       o_ctl_ack,
    output logic [7:0] o_tx_data,
    output logic       o_tx_data_valid,
    output logic       o_busy_res,
    output logic       o_has_data,
    output logic [7:0] o_read_byte
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

    logic          r_in_valid;
    logic [2:0]    r_op;
    logic [2:0]    r_tx_index;
    logic [7:0]    r_byte;
    logic [6:0]    r_addr;
    logic [3:0]    r_count;
    logic [7:0]    r_status;

    logic [CW-1:0] r_tx_length;
    logic [CW-1:0] r_tx_position;
    logic [CW-1:0] r_rx_expected;
    logic [CW-1:0] r_rx_position;
    logic          r_busy;

    logic          r_out_valid;
    imts_pkg::t_ctl r_ctl;
    logic          r_tx_valid;
    logic          r_has_data;
    logic          r_rd_mem;
    logic          r_rd_empty;

    logic [CW-1:0] n_tx_length;
    logic [CW-1:0] n_tx_position;
    logic [CW-1:0] n_rx_expected;
    logic [CW-1:0] n_rx_position;
    logic          n_busy;
    imts_pkg::t_ctl n_ctl;
    logic          n_tx_valid;
    logic          n_rd_mem;
    logic          n_rd_empty;

    logic          advance;
    logic          fire;

    logic          tx_we;
    logic [AW-1:0] tx_waddr;
    logic [7:0]    tx_wdata;
    logic          tx_re;
    logic [AW-1:0] tx_raddr;
    logic [7:0]    tx_rdata;

    logic          rx_we;
    logic [AW-1:0] rx_waddr;
    logic          rx_re;
    logic [AW-1:0] rx_raddr;
    logic [7:0]    rx_rdata;

    logic [7:0]    load_pos;
    logic [7:0]    count_ext;
    logic [7:0]    count_clip;
    logic [CW-1:0] send_pos;
    logic [CW:0]   ack_next;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op       <= i_operation;
            r_tx_index <= i_tx_index;
            r_byte     <= i_byte_value;
            r_addr     <= i_slave_address;
            r_count    <= i_byte_count;
            r_status   <= i_status_code;
        end
    end

    always_comb begin
        n_tx_length   = r_tx_length;
        n_tx_position = r_tx_position;
        n_rx_expected = r_rx_expected;
        n_rx_position = r_rx_position;
        n_busy        = r_busy;
        n_ctl         = '0;
        n_tx_valid    = 1'b0;
        n_rd_mem      = 1'b0;
        n_rd_empty    = 1'b0;
        tx_we         = 1'b0;
        tx_waddr      = '0;
        tx_wdata      = r_byte;
        tx_re         = 1'b0;
        tx_raddr      = '0;
        rx_we         = 1'b0;
        rx_waddr      = r_rx_position[AW-1:0];
        rx_re         = 1'b0;
        rx_raddr      = '0;
        load_pos      = {5'd0, r_tx_index} + 8'd1;
        count_ext     = {4'd0, r_count};
        count_clip    = count_ext;
        send_pos      = r_tx_position;
        ack_next      = '0;

        unique case (imts_pkg::t_op'(r_op))
            imts_pkg::OP_LOAD: begin
                if (load_pos < 8'(BUFFER_DEPTH)) begin
                    tx_we    = 1'b1;
                    tx_waddr = load_pos[AW-1:0];
                end
            end
            imts_pkg::OP_WRITE: begin
                tx_we    = 1'b1;
                tx_wdata = {r_addr, 1'b0};
                if (count_ext > 8'(BUFFER_DEPTH - 1)) begin
                    count_clip = 8'(BUFFER_DEPTH - 1);
                end
                n_tx_length = CW'(count_clip + 8'd1);
                n_ctl       = '{write: 1'b1, enable: 1'b1, int_enable: 1'b1,
                                clear_flag: 1'b1, start: 1'b1, default: 1'b0};
                n_busy      = 1'b1;
            end
            imts_pkg::OP_READ: begin
                tx_we    = 1'b1;
                tx_wdata = {r_addr, 1'b1};
                n_tx_length = CW'(1);
                if (count_ext > 8'(BUFFER_DEPTH)) begin
                    count_clip = 8'(BUFFER_DEPTH);
                end
                n_rx_expected = CW'(count_clip);
                n_ctl       = '{write: 1'b1, enable: 1'b1, int_enable: 1'b1,
                                clear_flag: 1'b1, start: 1'b1, default: 1'b0};
                n_busy      = 1'b1;
            end
            imts_pkg::OP_EVENT: begin
                unique case (r_status) inside
                    imts_pkg::ST_START, imts_pkg::ST_REP_START,
                    imts_pkg::ST_W_ADR_ACK, imts_pkg::ST_W_DATA_ACK: begin
                        if (r_status == imts_pkg::ST_START ||
                            r_status == imts_pkg::ST_REP_START) begin
                            send_pos = '0;
                        end
                        n_tx_position = send_pos;
                        if (send_pos < r_tx_length && send_pos < CW'(BUFFER_DEPTH)) begin
                            tx_re         = 1'b1;
                            tx_raddr      = send_pos[AW-1:0];
                            n_tx_valid    = 1'b1;
                            n_tx_position = send_pos + CW'(1);
                            n_ctl = '{write: 1'b1, enable: 1'b1, int_enable: 1'b1,
                                      clear_flag: 1'b1, default: 1'b0};
                        end else begin
                            n_ctl = '{write: 1'b1, enable: 1'b1, clear_flag: 1'b1,
                                      stop: 1'b1, default: 1'b0};
                            n_busy = 1'b0;
                        end
                    end
                    imts_pkg::ST_R_ADR_ACK: begin
                        n_rx_position = '0;
                        n_ctl = '{write: 1'b1, enable: 1'b1, int_enable: 1'b1,
                                  clear_flag: 1'b1, default: 1'b0};
                        n_ctl.ack = (r_rx_expected >= CW'(2));
                    end
                    imts_pkg::ST_R_DATA_ACK: begin
                        if (r_rx_position < CW'(BUFFER_DEPTH)) begin
                            rx_we         = 1'b1;
                            n_rx_position = r_rx_position + CW'(1);
                        end
                        ack_next = {1'b0, n_rx_position} + (CW + 1)'(1);
                        n_ctl = '{write: 1'b1, enable: 1'b1, int_enable: 1'b1,
                                  clear_flag: 1'b1, default: 1'b0};
                        n_ctl.ack = (ack_next < {1'b0, r_rx_expected});
                    end
                    imts_pkg::ST_R_DATA_NACK: begin
                        if (r_rx_position < CW'(BUFFER_DEPTH)) begin
                            rx_we         = 1'b1;
                            n_rx_position = r_rx_position + CW'(1);
                        end
                        n_ctl = '{write: 1'b1, enable: 1'b1, clear_flag: 1'b1,
                                  stop: 1'b1, default: 1'b0};
                        n_busy = 1'b0;
                    end
                    imts_pkg::ST_ARB_LOST: begin
                        n_ctl = '{write: 1'b1, enable: 1'b1, int_enable: 1'b1,
                                  clear_flag: 1'b1, start: 1'b1, default: 1'b0};
                    end
                    default: begin
                        n_ctl  = '{write: 1'b1, enable: 1'b1, default: 1'b0};
                        n_busy = 1'b0;
                    end
                endcase
            end
            imts_pkg::OP_POP: begin
                if (r_rx_position != '0) begin
                    n_rx_position = r_rx_position - CW'(1);
                    rx_re         = 1'b1;
                    rx_raddr      = n_rx_position[AW-1:0];
                    n_rd_mem      = 1'b1;
                end else begin
                    n_rd_empty = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_length   <= '0;
            r_tx_position <= '0;
            r_rx_expected <= '0;
            r_rx_position <= '0;
            r_busy        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_tx_length   <= n_tx_length;
                r_tx_position <= n_tx_position;
                r_rx_expected <= n_rx_expected;
                r_rx_position <= n_rx_position;
                r_busy        <= n_busy;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ctl      <= n_ctl;
            r_tx_valid <= n_tx_valid;
            r_has_data <= (n_rx_position != '0);
            r_rd_mem   <= n_rd_mem;
            r_rd_empty <= n_rd_empty;
        end
    end

    imts_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_tx_store (
        .i_clk   (i_clk),
        .i_we    (fire && tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (tx_wdata),
        .i_re    (fire && tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    imts_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_rx_store (
        .i_clk   (i_clk),
        .i_we    (fire && rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (r_byte),
        .i_re    (fire && rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    assign o_out_valid      = r_out_valid;
    assign o_ctl_write      = r_ctl.write;
    assign o_ctl_enable     = r_ctl.enable;
    assign o_ctl_int_enable = r_ctl.int_enable;
    assign o_ctl_clear_flag = r_ctl.clear_flag;
    assign o_ctl_start      = r_ctl.start;
    assign o_ctl_stop       = r_ctl.stop;
    assign o_ctl_ack        = r_ctl.ack;
    assign o_tx_data        = r_tx_valid ? tx_rdata : 8'd0;
    assign o_tx_data_valid  = r_tx_valid;
    assign o_busy_res       = r_busy;
    assign o_has_data       = r_has_data;
    assign o_read_byte      = r_rd_mem ? rx_rdata :
                              (r_rd_empty ? imts_pkg::EMPTY_BYTE : 8'd0);

endmodule

// ===== hw/rtl/imts_ram.sv =====
// Generic single write port RAM with a registered, enabled read port.
module imts_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = imts_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
